### rtl/tilt_compensated_compass_heading_defines.svh
// assertion helpers shared by the design
`ifndef TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TCCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcch same-cycle check failed");

// next-cycle implication, checked out of reset
`define TCCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcch next-cycle check failed");

`endif

### rtl/tcch_pkg.sv
`default_nettype none
package tcch_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int COEF_FRAC_BITS = 13;
    localparam int TAB_LEN        = 24;
    localparam int NSTAGE         = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int W              = 40;
    localparam int NLANE          = 3;
    localparam int GUARD_BITS     = 8;
    localparam int MAG_W          = 24;
    localparam int PROD_W         = 33;
    localparam int SUM_W          = 35;

    localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [15:0] CENTIDEG_TURN   = 16'd36000;
    localparam logic [47:0] HEADING_ROUND   = 48'h0000_8000_0000;

    typedef enum logic [2:0] {
        REG_CAL_EN  = 3'd0,
        REG_HARD_X  = 3'd1,
        REG_HARD_Y  = 3'd2,
        REG_HARD_Z  = 3'd3,
        REG_SOFT_R0 = 3'd4,
        REG_SOFT_R1 = 3'd5,
        REG_SOFT_R2 = 3'd6
    } t_reg;

    typedef logic signed [W-1:0] t_val;

    typedef struct packed {
        t_val        x;
        t_val        y;
        logic [31:0] z;
        logic        vec;
        logic        zero;
    } t_lane;

    typedef struct packed {
        logic                   valid;
        t_lane [NLANE-1:0]      lane;
        t_val                   s0;
        t_val                   s1;
        t_val                   s2;
        logic [31:0]            ang;
    } t_stage;

    // last member sits in the lowest bits, so ax lands in word bits 15:0
    typedef struct packed {
        logic signed [15:0] mz;
        logic signed [15:0] my;
        logic signed [15:0] mx;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } t_sample;

    typedef struct packed {
        logic               enable;
        logic signed [15:0] hard_x;
        logic signed [15:0] hard_y;
        logic signed [15:0] hard_z;
        logic [47:0]        row0;
        logic [47:0]        row1;
        logic [47:0]        row2;
    } t_cal;

    typedef struct packed {
        logic                   valid;
        logic signed [15:0]     ax;
        logic signed [15:0]     ay;
        logic signed [15:0]     az;
        logic signed [MAG_W-1:0] mx;
        logic signed [MAG_W-1:0] my;
        logic signed [MAG_W-1:0] mz;
    } t_fix;

    function automatic logic [31:0] atan_of(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/tcch_cordic_cell.sv
`default_nettype none
module tcch_cordic_cell (
    input  tcch_pkg::t_lane i_lane,
    input  logic [4:0]      i_stage,
    output tcch_pkg::t_lane o_lane
);
    import tcch_pkg::*;

    t_val        xs;
    t_val        ys;
    logic        ccw;
    logic [31:0] step;

    always_comb begin
        xs   = i_lane.x >>> i_stage;
        ys   = i_lane.y >>> i_stage;
        step = atan_of(i_stage);
        // vectoring drives y to zero, rotation drives the residual angle to zero
        ccw  = i_lane.vec ? i_lane.y[W-1] : ~i_lane.z[31];
        o_lane = i_lane;
        if (!i_lane.zero) begin
            if (ccw) begin
                o_lane.x = i_lane.x - ys;
                o_lane.y = i_lane.y + xs;
                o_lane.z = i_lane.z - step;
            end else begin
                o_lane.x = i_lane.x + ys;
                o_lane.y = i_lane.y - xs;
                o_lane.z = i_lane.z + step;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/tcch_cordic_phase.sv
`default_nettype none
module tcch_cordic_phase (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  tcch_pkg::t_stage i_stage,
    output tcch_pkg::t_stage o_stage
);
    import tcch_pkg::*;

    t_stage r_st [0:NSTAGE];
    t_stage n_st [0:NSTAGE];
    t_lane  w_lane [0:NSTAGE-1][0:NLANE-1];

    // quadrant fold ahead of the iterations
    function automatic t_lane fold(input t_lane l);
        t_lane o;
        o = l;
        if (l.vec) begin
            o.zero = (l.x == '0) && (l.y == '0);
            o.z    = '0;
            if (l.x[W-1]) begin
                o.x = -l.x;
                o.y = -l.y;
                o.z = HALF_TURN;
            end
        end else begin
            o.zero = 1'b0;
            if ($signed(l.z) > $signed(QUARTER_TURN) || $signed(l.z) < -$signed(QUARTER_TURN)) begin
                o.x = -l.x;
                o.y = -l.y;
                o.z = l.z + HALF_TURN;
            end
        end
        return o;
    endfunction

    genvar k, l;
    generate
        for (k = 0; k < NSTAGE; k++) begin : g_col
            for (l = 0; l < NLANE; l++) begin : g_lane
                tcch_cordic_cell u_cell (
                    .i_lane  (r_st[k].lane[l]),
                    .i_stage (5'(k)),
                    .o_lane  (w_lane[k][l])
                );
            end
        end
    endgenerate

    always_comb begin
        n_st[0] = i_stage;
        for (int j = 0; j < NLANE; j++) begin
            n_st[0].lane[j] = fold(i_stage.lane[j]);
        end
        for (int c = 0; c < NSTAGE; c++) begin
            n_st[c+1] = r_st[c];
            for (int j = 0; j < NLANE; j++) begin
                n_st[c+1].lane[j] = w_lane[c][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c <= NSTAGE; c++) begin
            if (!i_rst_n) begin
                r_st[c].valid <= 1'b0;
            end else if (i_en) begin
                r_st[c] <= n_st[c];
            end
        end
    end

    assign o_stage = r_st[NSTAGE];

endmodule
`default_nettype wire

### rtl/tcch_soft_iron.sv
`default_nettype none
module tcch_soft_iron (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tcch_pkg::t_sample i_sample,
    input  tcch_pkg::t_cal    i_cal,
    output tcch_pkg::t_fix    o_fix
);
    import tcch_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (MAG_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (MAG_W - 1));

    logic                     r_v1, r_v2;
    t_sample                  r_s1, r_s2;
    logic signed [16:0]       r_c [0:2];
    logic signed [PROD_W-1:0] r_p [0:2][0:2];
    t_fix                     r_fix;
    t_fix                     n_fix;

    logic signed [15:0]       coef [0:2][0:2];
    logic signed [SUM_W-1:0]  sum  [0:2];
    logic signed [MAG_W-1:0]  sat  [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[0][r] = i_cal.row0[16*r +: 16];
            coef[1][r] = i_cal.row1[16*r +: 16];
            coef[2][r] = i_cal.row2[16*r +: 16];
        end
        for (int r = 0; r < 3; r++) begin
            sum[r] = SUM_W'(r_p[r][0]) + SUM_W'(r_p[r][1]) + SUM_W'(r_p[r][2]) + ROUND;
            sum[r] = sum[r] >>> COEF_FRAC_BITS;
            if (sum[r] > SAT_HI) begin
                sat[r] = SAT_HI[MAG_W-1:0];
            end else if (sum[r] < SAT_LO) begin
                sat[r] = SAT_LO[MAG_W-1:0];
            end else begin
                sat[r] = sum[r][MAG_W-1:0];
            end
        end
        n_fix.valid = r_v2;
        n_fix.ax    = r_s2.ax;
        n_fix.ay    = r_s2.ay;
        n_fix.az    = r_s2.az;
        if (i_cal.enable) begin
            n_fix.mx = sat[0];
            n_fix.my = sat[1];
            n_fix.mz = sat[2];
        end else begin
            n_fix.mx = MAG_W'(r_s2.mx);
            n_fix.my = MAG_W'(r_s2.my);
            n_fix.mz = MAG_W'(r_s2.mz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_fix.valid <= 1'b0;
        end else if (i_en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_fix <= n_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= i_sample;
            r_c[0] <= 17'(i_sample.mx) - 17'(i_cal.hard_x);
            r_c[1] <= 17'(i_sample.my) - 17'(i_cal.hard_y);
            r_c[2] <= 17'(i_sample.mz) - 17'(i_cal.hard_z);
            r_s2   <= r_s1;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(r_c[c]);
                end
            end
        end
    end

    assign o_fix = r_fix;

endmodule
`default_nettype wire

### rtl/tilt_compensated_compass_heading.sv
// throughput: one word per cycle while the skid entry is empty; five CORDIC passes, fully pipelined
// a two-entry output (register plus skid) lets input flow while a result waits
// reset: synchronous active low; clears valids and loads calibration off, zero bias,
// identity soft-iron matrix
`default_nettype none
`include "tilt_compensated_compass_heading_defines.svh"
module tilt_compensated_compass_heading (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // heading_centideg
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import tcch_pkg::*;

    t_cal    r_cal;
    t_sample w_sample;
    t_fix    w_fix;
    t_stage  w_in [0:4];
    t_stage  w_out [0:4];
    logic    w_en;
    logic    r_pv;
    logic [47:0] r_prod;
    logic [47:0] w_round;
    logic [15:0] w_head;
    logic    r_out_valid, r_skid_valid;
    logic [15:0] r_out, r_skid;

    function automatic t_val scale(input logic signed [MAG_W-1:0] v);
        return t_val'(v) <<< GUARD_BITS;
    endfunction

    function automatic t_lane mk(input t_val x, input t_val y, input logic [31:0] z,
                                 input logic vec);
        t_lane o;
        o.x = x; o.y = y; o.z = z; o.vec = vec; o.zero = 1'b0;
        return o;
    endfunction

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.enable <= 1'b0;
            r_cal.hard_x <= '0;
            r_cal.hard_y <= '0;
            r_cal.hard_z <= '0;
            r_cal.row0   <= 48'h0000_0000_2000;
            r_cal.row1   <= 48'h0000_2000_0000;
            r_cal.row2   <= 48'h2000_0000_0000;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg'(paddr[5:3]))
                REG_CAL_EN:  r_cal.enable <= pwdata[0];
                REG_HARD_X:  r_cal.hard_x <= pwdata[15:0];
                REG_HARD_Y:  r_cal.hard_y <= pwdata[15:0];
                REG_HARD_Z:  r_cal.hard_z <= pwdata[15:0];
                REG_SOFT_R0: r_cal.row0   <= pwdata[47:0];
                REG_SOFT_R1: r_cal.row1   <= pwdata[47:0];
                REG_SOFT_R2: r_cal.row2   <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[5:3]))
            REG_CAL_EN:  prdata = 64'(r_cal.enable);
            REG_HARD_X:  prdata = 64'($unsigned(r_cal.hard_x));
            REG_HARD_Y:  prdata = 64'($unsigned(r_cal.hard_y));
            REG_HARD_Z:  prdata = 64'($unsigned(r_cal.hard_z));
            REG_SOFT_R0: prdata = 64'(r_cal.row0);
            REG_SOFT_R1: prdata = 64'(r_cal.row1);
            REG_SOFT_R2: prdata = 64'(r_cal.row2);
            default:     prdata = '0;
        endcase
    end

    // whole datapath moves unless the skid entry is occupied
    assign w_en     = ~r_skid_valid;
    assign s_tready = w_en;
    assign w_sample = s_tdata;

    tcch_soft_iron u_soft (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_tvalid & s_tready),
        .i_sample (w_sample),
        .i_cal    (r_cal),
        .o_fix    (w_fix)
    );

    always_comb begin
        for (int p = 0; p < 5; p++) begin
            w_in[p] = '0;
        end
        // roll, gained -ax, gained my
        w_in[0].valid   = w_fix.valid;
        w_in[0].lane[0] = mk(scale(MAG_W'(w_fix.az)), scale(MAG_W'(w_fix.ay)), '0, 1'b1);
        w_in[0].lane[1] = mk(-scale(MAG_W'(w_fix.ax)), '0, '0, 1'b0);
        w_in[0].lane[2] = mk(scale(w_fix.my), '0, '0, 1'b0);
        w_in[0].s0      = scale(w_fix.mx);
        w_in[0].s1      = scale(w_fix.mz);
        // pitch
        w_in[1].valid   = w_out[0].valid;
        w_in[1].lane[0] = mk(w_out[0].lane[0].x, w_out[0].lane[1].x, '0, 1'b1);
        w_in[1].s0      = w_out[0].s0;
        w_in[1].s1      = w_out[0].s1;
        w_in[1].s2      = w_out[0].lane[2].x;
        w_in[1].ang     = w_out[0].lane[0].z;
        // undo pitch on the x/z plane
        w_in[2].valid   = w_out[1].valid;
        w_in[2].lane[0] = mk(w_out[1].s0, w_out[1].s1, -w_out[1].lane[0].z, 1'b0);
        w_in[2].s2      = w_out[1].s2;
        w_in[2].ang     = w_out[1].ang;
        // match gain on x, undo roll on the y/z plane
        w_in[3].valid   = w_out[2].valid;
        w_in[3].lane[0] = mk(w_out[2].lane[0].x, '0, '0, 1'b0);
        w_in[3].lane[1] = mk(w_out[2].s2, w_out[2].lane[0].y, w_out[2].ang, 1'b0);
        // heading angle
        w_in[4].valid   = w_out[3].valid;
        w_in[4].lane[0] = mk(w_out[3].lane[0].x, -w_out[3].lane[1].x, '0, 1'b1);
    end

    genvar g;
    generate
        for (g = 0; g < 5; g++) begin : g_phase
            tcch_cordic_phase u_phase (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_stage (w_in[g]),
                .o_stage (w_out[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= w_out[4].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 48'(w_out[4].lane[0].z) * 48'(CENTIDEG_TURN);
        end
    end

    always_comb begin
        w_round = r_prod + HEADING_ROUND;
        w_head  = w_round[47:32];
        if (w_head >= CENTIDEG_TURN) begin
            w_head = '0;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !m_tready) begin
            if (r_pv && w_en) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !m_tready) begin
            if (r_pv && w_en) begin
                r_skid <= w_head;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else begin
            r_out <= w_head;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    `TCCH_ASSERT_NOW(a_head_range, m_tvalid, m_tdata < CENTIDEG_TURN)
    `TCCH_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid && !s_tready)
    `TCCH_ASSERT_NEXT(a_stall_to_skid, r_out_valid && !m_tready && r_pv && w_en, r_skid_valid)

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tcch_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 120;

    class heading_scoreboard;
        bit          cal_on;
        longint      bias_x, bias_y, bias_z;
        bit [47:0]   row0, row1, row2;
        bit [15:0]   pending[$];
        int          mismatches;
        int          results_seen;
        bit [31:0]   arctan[24];

        function new();
            arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                       32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                       32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                       32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                       32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                       32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
            cal_on = 0;
            bias_x = 0; bias_y = 0; bias_z = 0;
            row0 = 48'd8192; row1 = 48'd536870912; row2 = 48'd35184372088832;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function longint sext16(bit [15:0] v);
            return longint'(signed'(v));
        endfunction

        function void set_reg(t_reg idx, bit [63:0] v);
            case (idx)
                REG_CAL_EN:  cal_on = v[0];
                REG_HARD_X:  bias_x = sext16(v[15:0]);
                REG_HARD_Y:  bias_y = sext16(v[15:0]);
                REG_HARD_Z:  bias_z = sext16(v[15:0]);
                REG_SOFT_R0: row0 = v[47:0];
                REG_SOFT_R1: row1 = v[47:0];
                REG_SOFT_R2: row2 = v[47:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] vectoring(longint x, longint y, output longint mag);
            bit [31:0] z;
            longint xs, ys;
            z = 0;
            if (x == 0 && y == 0) begin
                mag = 0;
                return 0;
            end
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (int i = 0; i < NSTAGE; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y < 0) begin
                    x = x - ys; y = y + xs; z = z - arctan[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + arctan[i];
                end
            end
            mag = x;
            return z;
        endfunction

        function void rotate(inout longint x, inout longint y, input bit [31:0] ang);
            longint a, xs, ys;
            a = longint'(signed'(ang));
            if (a > 64'sh40000000 || a < -64'sh40000000) begin
                x = -x;
                y = -y;
                a = longint'(signed'(ang + HALF_TURN));
            end
            for (int i = 0; i < NSTAGE; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (a >= 0) begin
                    x = x - ys; y = y + xs; a = a - arctan[i];
                end else begin
                    x = x + ys; y = y - xs; a = a + arctan[i];
                end
            end
        endfunction

        function longint with_gain(longint v);
            longint y;
            y = 0;
            rotate(v, y, 0);
            return v;
        endfunction

        function longint soft_axis(bit [47:0] r, longint c0, longint c1, longint c2);
            longint s;
            s = sext16(r[15:0]) * c0 + sext16(r[31:16]) * c1 + sext16(r[47:32]) * c2;
            s = (s + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (s > 8388607) s = 8388607;
            if (s < -8388608) s = -8388608;
            return s;
        endfunction

        function bit [15:0] heading_of(t_sample smp);
            longint ax, ay, az, mx, my, mz, c0, c1, c2;
            longint r1, r2, axk, a, b, a2, c, d, hmag;
            bit [31:0] roll, pitch, hang;
            bit [63:0] h;
            ax = smp.ax; ay = smp.ay; az = smp.az;
            mx = smp.mx; my = smp.my; mz = smp.mz;
            if (cal_on) begin
                c0 = mx - bias_x; c1 = my - bias_y; c2 = mz - bias_z;
                mx = soft_axis(row0, c0, c1, c2);
                my = soft_axis(row1, c0, c1, c2);
                mz = soft_axis(row2, c0, c1, c2);
            end
            ax = ax * 256; ay = ay * 256; az = az * 256;
            mx = mx * 256; my = my * 256; mz = mz * 256;
            roll = vectoring(az, ay, r1);
            axk = with_gain(-ax);
            pitch = vectoring(r1, axk, r2);
            a = mx;
            b = mz;
            rotate(a, b, 32'd0 - pitch);
            a2 = with_gain(a);
            c = with_gain(my);
            d = b;
            rotate(c, d, roll);
            hang = vectoring(a2, -c, hmag);
            h = ({32'd0, hang} * 64'd36000 + 64'h80000000) >> 32;
            if (h >= 64'd36000) h = 0;
            return h[15:0];
        endfunction

        function void note_sample(t_sample smp);
            pending.push_back(heading_of(smp));
        endfunction

        function void check_heading(bit [15:0] got);
            bit [15:0] want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected heading word %0d", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("heading mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    heading_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles = 0;
    int samples_sent;

    tilt_compensated_compass_heading u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // both handshakes are sampled mid-cycle, where everything is settled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_sample(t_sample'(s_tdata));
            if (m_tvalid && m_tready) sb.check_heading(m_tdata);
        end
    end

    function automatic logic [95:0] pack_word(logic [15:0] ax, ay, az, mx, my, mz);
        return {mz, my, mx, az, ay, ax};
    endfunction

    task automatic send_word(logic [95:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic write_unused(logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 6'd56; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'($urandom_range(64) - 32);
            1: return 16'h7FFF - 16'($urandom_range(3));
            2: return 16'h8000 + 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] near_unity();
        return 16'(8192 + $urandom_range(1600) - 800);
    endfunction

    function automatic logic [15:0] small_coef();
        return 16'($urandom_range(1200) - 600);
    endfunction

    task automatic random_samples(int n);
        for (int k = 0; k < n; k++)
            send_word(pack_word(rand_axis(), rand_axis(), rand_axis(),
                                rand_axis(), rand_axis(), rand_axis()));
    endtask

    task automatic directed_samples();
        send_word(pack_word(0, 0, 0, 0, 0, 0));
        send_word(pack_word(0, 0, 0, 1000, 0, 0));
        send_word(pack_word(0, 0, 0, 1000, 16'hFFFF, 0));
        send_word(pack_word(0, 0, 16000, 1000, 1, 0));
        send_word(pack_word(0, 0, 16000, 0, 0, 500));
        send_word(pack_word(0, 0, 16000, 0, 1000, 0));
        send_word(pack_word(0, 0, 16000, 16'hFC18, 0, 0));
        send_word(pack_word(0, 0, 16000, 0, 16'hFC18, 0));
        send_word(pack_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_word(pack_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_word(pack_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_word(pack_word(16'h8000, 0, 0, 300, 200, 16'h8000));
        send_word(pack_word(0, 16'h7FFF, 0, 300, 16'hFF00, 400));
        send_word(pack_word(0, 0, 16'h8000, 300, 200, 100));
        send_word(pack_word(5000, 16'hEC78, 12000, 16'h7FFF, 0, 16'h8000));
        send_word(pack_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(pack_word(0, 0, 1, 30000, 16'hFFFF, 0));
        send_word(pack_word(0, 0, 1, 30000, 1, 0));
    endtask

    initial begin
        sb = new();
        samples_sent = 0;
        send_idle_pct = 15;
        recv_idle_pct = 86;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // raw magnetometer path at reset defaults
        directed_samples();
        random_samples(110);
        go_quiet();

        // calibration on, identity rows with x and y bias at the extremes
        write_reg(REG_CAL_EN, 64'd1);
        write_reg(REG_HARD_X, 64'h7FFF);
        write_reg(REG_HARD_Y, 64'hFFFF_FFFF_FFFF_8000);
        write_reg(REG_HARD_Z, 64'd0);
        write_reg(REG_SOFT_R0, 64'h0000_0000_0000_2000);
        write_reg(REG_SOFT_R1, 64'h0000_0000_2000_0000);
        write_reg(REG_SOFT_R2, 64'hFFFF_2000_0000_0000);
        write_unused(64'h1234);
        directed_samples();
        random_samples(40);
        go_quiet();

        // extreme coefficients drive the corrected axes into saturation
        write_reg(REG_HARD_X, 64'h8000);
        write_reg(REG_HARD_Y, 64'h7FFF);
        write_reg(REG_HARD_Z, 64'h8000);
        write_reg(REG_SOFT_R0, 64'h7FFF_7FFF_7FFF);
        write_reg(REG_SOFT_R1, 64'h8000_8000_8000);
        write_reg(REG_SOFT_R2, 64'h7FFF_8000_7FFF);
        random_samples(40);
        go_quiet();

        send_idle_pct = 86;
        recv_idle_pct = 15;
        // realistic calibration, redrawn a few times
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_HARD_X, 64'($urandom));
            write_reg(REG_HARD_Y, 64'($urandom));
            write_reg(REG_HARD_Z, 64'($urandom));
            write_reg(REG_SOFT_R0, {16'h0, small_coef(), small_coef(), near_unity()});
            write_reg(REG_SOFT_R1, {16'h0, small_coef(), near_unity(), small_coef()});
            write_reg(REG_SOFT_R2, {16'h0, near_unity(), small_coef(), small_coef()});
            random_samples(40);
            go_quiet();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SOFT_R0, {$urandom, $urandom});
        write_reg(REG_SOFT_R1, {$urandom, $urandom});
        write_reg(REG_SOFT_R2, {$urandom, $urandom});
        random_samples(40);
        go_quiet();
        write_reg(REG_CAL_EN, 64'd0);
        random_samples(60);
        go_quiet();

        $display("sent %0d samples, checked %0d headings, %0d mismatches",
                 samples_sent, sb.results_seen, sb.mismatches);
        $display("covered raw and calibrated paths, saturating coefficients and stall mixes");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
